// File: rtl/core/usr_pkg.sv
// ----------------------------------------------------------------------------
// usr_pkg
// Types, request codes and descriptor tables shared by the request responder.
// ----------------------------------------------------------------------------
package usr_pkg;

    localparam int DEV_LEN         = 18;
    localparam int CFG_LEN         = 34;
    localparam int STR_LEN         = 4;
    localparam int CFG_EP_ADDR_POS = 29;
    localparam int IDX_W           = $clog2(CFG_LEN);

    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_GET_INTERFACE  = 8'd10;
    localparam logic [7:0] REQ_SET_INTERFACE  = 8'd11;

    localparam logic [1:0] TYPE_STANDARD = 2'd0;

    localparam logic [7:0] DESC_DEVICE = 8'd1;
    localparam logic [7:0] DESC_CONFIG = 8'd2;
    localparam logic [7:0] DESC_STRING = 8'd3;

    localparam logic [3:0] EP_DIR_IN = 4'h8;

    localparam logic [7:0] DEV_DESC [DEV_LEN] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
        8'h6d, 8'h04, 8'h12, 8'hc3, 8'h00, 8'h00, 8'h00, 8'h01,
        8'h02, 8'h01
    };

    localparam logic [7:0] CFG_SET [CFG_LEN] = '{
        8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h03, 8'hc0, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h04,
        8'h09, 8'h21, 8'h10, 8'h01, 8'h00, 8'h01, 8'h22, 8'h41, 8'h00,
        8'h07, 8'h05, 8'h80, 8'h03, 8'h08, 8'h00, 8'h05
    };

    localparam logic [7:0] STR_LANG [STR_LEN] = '{8'h04, 8'h03, 8'h09, 8'h04};
    localparam logic [7:0] STR_X    [STR_LEN] = '{8'h04, 8'h03, 8'h78, 8'h00};

    typedef enum logic [2:0] {
        K_NONE,
        K_EMPTY,
        K_ZERO,
        K_DEV,
        K_CFG,
        K_STR_LANG,
        K_STR_X
    } t_kind;

    typedef struct packed {
        t_kind kind;
    } t_job;

    function automatic logic [IDX_W-1:0] job_len(input t_kind kind);
        logic [IDX_W-1:0] len;
        case (kind)
            K_DEV:              len = IDX_W'(DEV_LEN);
            K_CFG:              len = IDX_W'(CFG_LEN);
            K_STR_LANG, K_STR_X: len = IDX_W'(STR_LEN);
            default:            len = IDX_W'(1);
        endcase
        return len;
    endfunction

endpackage

// File: rtl/core/usr_decode.sv
// ----------------------------------------------------------------------------
// usr_decode
// Classifies one SETUP request into the kind of response it gets.
// ----------------------------------------------------------------------------
module usr_decode (
    input  logic [7:0]     i_request_type,
    input  logic [7:0]     i_request_code,
    input  logic [15:0]    i_request_value,
    output usr_pkg::t_job  o_job
);
    import usr_pkg::*;

    logic [7:0] dtype;
    logic [7:0] dindex;

    assign dtype  = i_request_value[15:8];
    assign dindex = i_request_value[7:0];

    always_comb begin
        o_job.kind = K_NONE;
        if (i_request_type[6:5] == TYPE_STANDARD) begin
            case (i_request_code)
                REQ_GET_DESCRIPTOR: begin
                    case (dtype)
                        DESC_DEVICE: o_job.kind = K_DEV;
                        DESC_CONFIG: o_job.kind = K_CFG;
                        DESC_STRING: o_job.kind = (dindex == 8'd0) ? K_STR_LANG : K_STR_X;
                        default:     o_job.kind = K_NONE;
                    endcase
                end
                REQ_GET_CONFIG:    o_job.kind = K_CFG;
                REQ_GET_INTERFACE: o_job.kind = K_ZERO;
                REQ_SET_INTERFACE: o_job.kind = K_EMPTY;
                default:           o_job.kind = K_NONE;
            endcase
        end
    end

endmodule

// File: rtl/core/usr_emitter.sv
// ----------------------------------------------------------------------------
// usr_emitter
// Steps through the selected response one byte per cycle into the result
// register.
// ----------------------------------------------------------------------------
module usr_emitter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  usr_pkg::t_job  i_job,
    input  logic [3:0]     i_endpoint_number,
    output logic           o_busy,
    output logic           o_strobe,
    output logic           o_handled,
    output logic           o_byte_valid,
    output logic [7:0]     o_response_byte,
    output logic           o_last
);
    import usr_pkg::*;

    logic             r_active;
    t_kind            r_kind;
    logic [IDX_W-1:0] r_idx;

    logic             last_now;
    logic [7:0]       cur_byte;

    logic             r_strobe;
    logic             r_handled;
    logic             r_byte_valid;
    logic [7:0]       r_response_byte;
    logic             r_last;

    assign last_now = (r_idx == job_len(r_kind) - IDX_W'(1));
    // The final byte frees the sequencer, so the next request loads in that cycle.
    assign o_busy   = r_active && !last_now;

    always_comb begin
        case (r_kind)
            K_DEV:      cur_byte = DEV_DESC[r_idx[$clog2(DEV_LEN)-1:0]];
            K_CFG:      cur_byte = (r_idx == IDX_W'(CFG_EP_ADDR_POS))
                                   ? {EP_DIR_IN, i_endpoint_number} : CFG_SET[r_idx];
            K_STR_LANG: cur_byte = STR_LANG[r_idx[$clog2(STR_LEN)-1:0]];
            K_STR_X:    cur_byte = STR_X[r_idx[$clog2(STR_LEN)-1:0]];
            default:    cur_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_strobe <= 1'b0;
            r_kind   <= K_NONE;
            r_idx    <= '0;
        end else begin
            r_strobe <= r_active;
            if (i_load) begin
                r_active <= 1'b1;
                r_kind   <= i_job.kind;
                r_idx    <= '0;
            end else if (r_active) begin
                if (last_now) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_handled       <= (r_kind != K_NONE);
        r_byte_valid    <= (r_kind != K_NONE) && (r_kind != K_EMPTY);
        r_response_byte <= cur_byte;
        r_last          <= last_now;
    end

    assign o_strobe        = r_strobe;
    assign o_handled       = r_handled;
    assign o_byte_valid    = r_byte_valid;
    assign o_response_byte = r_response_byte;
    assign o_last          = r_last;

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !o_busy)
        else $error("request loaded while sequencer busy");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx < job_len(r_kind)))
        else $error("byte index past response length");

    a_strobe_follows_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(r_active))
        else $error("result strobe without active response");

    a_unhandled_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_handled) |-> (r_last && !r_byte_valid && r_response_byte == 8'h00))
        else $error("no-response result not a single empty item");

endmodule

// File: rtl/core/usb_standard_request_responder.sv
// ----------------------------------------------------------------------------
// usb_standard_request_responder
// Answers standard USB SETUP requests for a HID keyboard device.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The accepting edge
// loads the sequencer; its first result is registered onto the result ports,
// and the rest follow one per cycle with o_strobe high; they cannot be
// held off. A request produces 1, 4, 18 or 34 results (no response, empty
// reply or one zero byte; string; device descriptor; configuration set), and
// the byte counter of the response sequencer sets that figure: busy stays
// high until the cycle that produces the final byte, in which the next
// request can already be taken, so requests follow with no gap.
// The endpoint number register is written over the cfg channel, which is
// always ready; write it only while no transfer is pending.
module usb_standard_request_responder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_request_type,
    input  logic [7:0]  i_request_code,
    input  logic [15:0] i_request_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_strobe,
    output logic        o_handled,
    output logic        o_byte_valid,
    output logic [7:0]  o_response_byte,
    output logic        o_last
);
    import usr_pkg::*;

    logic [3:0] r_ep;
    t_job       job;
    logic       load;

    assign o_cfg_ready = 1'b1;
    assign load        = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ep <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_ep <= i_cfg_data;
        end
    end

    usr_decode u_decode (
        .i_request_type  (i_request_type),
        .i_request_code  (i_request_code),
        .i_request_value (i_request_value),
        .o_job           (job)
    );

    usr_emitter u_emitter (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (load),
        .i_job             (job),
        .i_endpoint_number (r_ep),
        .o_busy            (busy),
        .o_strobe          (o_strobe),
        .o_handled         (o_handled),
        .o_byte_valid      (o_byte_valid),
        .o_response_byte   (o_response_byte),
        .o_last            (o_last)
    );

    a_cfg_reg_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_ep == $past(i_cfg_data)))
        else $error("endpoint register did not take the written value");

endmodule

// File: tb/usb_standard_request_responder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_standard_request_responder_test
// Sends SETUP requests to the responder and checks every response transfer
// against a predictor of the descriptor tables. A directed table covers the
// extremes and each no-response, empty-reply and string case. Random
// requests follow, mostly well-formed, over several endpoint numbers.
// ----------------------------------------------------------------------------
module usb_standard_request_responder_test;

    import usr_pkg::*;

    localparam logic [7:0] REQ_GET_STATUS     = 8'd0;
    localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;
    localparam logic [7:0] REQ_SYNCH_FRAME    = 8'd12;
    localparam logic [7:0] DESC_OTHER_SPEED   = 8'd7;

    localparam int RUN_LIMIT    = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 51;

    typedef struct packed {
        logic       handled;
        logic       byte_valid;
        logic [7:0] data;
        logic       last;
    } t_reply;

    typedef struct packed {
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] value;
        logic        fixed;
        t_reply      reply;
    } t_setup_row;

    localparam t_reply R_NONE  = '{1'b0, 1'b0, 8'h00, 1'b1};
    localparam t_reply R_EMPTY = '{1'b1, 1'b0, 8'h00, 1'b1};
    localparam t_reply R_ZERO  = '{1'b1, 1'b1, 8'h00, 1'b1};
    localparam t_reply R_CALC  = '{1'b0, 1'b0, 8'h00, 1'b0};

    localparam logic [7:0] DEVICE_BYTES [18] = '{
        8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h40,
        8'h6d, 8'h04, 8'h12, 8'hc3, 8'h00, 8'h00, 8'h00, 8'h01,
        8'h02, 8'h01
    };

    localparam logic [7:0] CONFIG_BYTES [34] = '{
        8'h09, 8'h02, 8'h22, 8'h00, 8'h01, 8'h01, 8'h03, 8'hc0, 8'h32,
        8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h04,
        8'h09, 8'h21, 8'h10, 8'h01, 8'h00, 8'h01, 8'h22, 8'h41, 8'h00,
        8'h07, 8'h05, 8'h80, 8'h03, 8'h08, 8'h00, 8'h05
    };
    localparam int EP_ADDR_AT = 29;

    // Single-transfer answers are typed in; longer ones come from the predictor.
    localparam t_setup_row DIRECTED [22] = '{
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h0100, 1'b0, R_CALC},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h0200, 1'b0, R_CALC},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h0300, 1'b0, R_CALC},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h03ff, 1'b0, R_CALC},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h0301, 1'b0, R_CALC},
        '{8'h80, REQ_GET_CONFIG,     16'h0000, 1'b0, R_CALC},
        '{8'h81, REQ_GET_INTERFACE,  16'h0000, 1'b1, R_ZERO},
        '{8'h01, REQ_SET_INTERFACE,  16'h0001, 1'b1, R_EMPTY},
        '{8'h00, REQ_SET_CONFIG,     16'h0001, 1'b1, R_NONE},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h0000, 1'b1, R_NONE},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'h0400, 1'b1, R_NONE},
        '{8'h80, REQ_GET_DESCRIPTOR, {DESC_OTHER_SPEED, 8'h00}, 1'b1, R_NONE},
        '{8'h80, REQ_GET_DESCRIPTOR, 16'hffff, 1'b1, R_NONE},
        '{8'ha1, REQ_GET_DESCRIPTOR, 16'h0100, 1'b1, R_NONE},
        '{8'hc0, REQ_GET_CONFIG,     16'h0000, 1'b1, R_NONE},
        '{8'he0, REQ_GET_INTERFACE,  16'h0000, 1'b1, R_NONE},
        '{8'hff, 8'hff,              16'hffff, 1'b1, R_NONE},
        '{8'h00, REQ_GET_STATUS,     16'h0000, 1'b1, R_NONE},
        '{8'h9f, REQ_GET_DESCRIPTOR, 16'h01ff, 1'b0, R_CALC},
        '{8'h1f, REQ_SET_INTERFACE,  16'hffff, 1'b1, R_EMPTY},
        '{8'h00, REQ_SET_DESCRIPTOR, 16'h0100, 1'b1, R_NONE},
        '{8'h80, REQ_SYNCH_FRAME,    16'h0000, 1'b1, R_NONE}
    };

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic [7:0]  i_request_type  = 8'h00;
    logic [7:0]  i_request_code  = 8'h00;
    logic [15:0] i_request_value = 16'h0000;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data      = 4'h0;
    logic        o_strobe;
    logic        o_handled;
    logic        o_byte_valid;
    logic [7:0]  o_response_byte;
    logic        o_last;

    // Typed-in answer that travels with the request on the bus.
    logic        row_fixed = 1'b0;
    t_reply      row_reply = R_CALC;

    t_reply      expected_replies [$];
    logic [3:0]  endpoint_shadow = 4'h0;
    int          error_count = 0;
    int          cycle_count = 0;

    usb_standard_request_responder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_request_type  (i_request_type),
        .i_request_code  (i_request_code),
        .i_request_value (i_request_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_handled       (o_handled),
        .o_byte_valid    (o_byte_valid),
        .o_response_byte (o_response_byte),
        .o_last          (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void flag_error(input string what, input t_reply want,
                                       input t_reply got);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("%s: expected h=%0b v=%0b byte=%02h last=%0b,",
                     what, want.handled, want.byte_valid, want.data, want.last,
                     " got h=%0b v=%0b byte=%02h last=%0b",
                     got.handled, got.byte_valid, got.data, got.last);
        end
    endfunction

    // Queues every transfer that one SETUP request should produce.
    function automatic void predict_reply(input logic [7:0] rtype, input logic [7:0] code,
                                          input logic [15:0] value, input logic [3:0] ep);
        logic [7:0] payload [$];
        logic       as_config;
        as_config = 1'b0;
        if (rtype[6:5] != TYPE_STANDARD) begin
            expected_replies.push_back(R_NONE);
            return;
        end
        case (code)
            REQ_GET_DESCRIPTOR: begin
                if (value[15:8] == DESC_DEVICE) begin
                    foreach (DEVICE_BYTES[i]) payload.push_back(DEVICE_BYTES[i]);
                end else if (value[15:8] == DESC_CONFIG) begin
                    as_config = 1'b1;
                end else if (value[15:8] == DESC_STRING) begin
                    if (value[7:0] == 8'h00) payload = '{8'h04, 8'h03, 8'h09, 8'h04};
                    else                     payload = '{8'h04, 8'h03, 8'h78, 8'h00};
                end else begin
                    expected_replies.push_back(R_NONE);
                    return;
                end
            end
            REQ_GET_CONFIG: as_config = 1'b1;
            REQ_GET_INTERFACE: begin
                expected_replies.push_back(R_ZERO);
                return;
            end
            REQ_SET_INTERFACE: begin
                expected_replies.push_back(R_EMPTY);
                return;
            end
            default: begin
                expected_replies.push_back(R_NONE);
                return;
            end
        endcase
        if (as_config) begin
            foreach (CONFIG_BYTES[i]) payload.push_back(CONFIG_BYTES[i]);
            payload[EP_ADDR_AT] = {4'h8, ep};
        end
        foreach (payload[i]) begin
            expected_replies.push_back('{1'b1, 1'b1, payload[i], i == payload.size() - 1});
        end
    endfunction

    // Register writes, request acceptance and result checking all share one
    // edge-sampled process, so their order inside a time step is fixed.
    always @(posedge i_clk) begin : monitor
        t_reply got;
        t_reply want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) endpoint_shadow = i_cfg_data;
            if (start && !busy) begin
                if (row_fixed) expected_replies.push_back(row_reply);
                else predict_reply(i_request_type, i_request_code, i_request_value,
                                   endpoint_shadow);
            end
            if (o_strobe) begin
                got = '{o_handled, o_byte_valid, o_response_byte, o_last};
                if (expected_replies.size() == 0) begin
                    flag_error("Unexpected transfer", R_CALC, got);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.handled !== want.handled || got.byte_valid !== want.byte_valid ||
                        got.data !== want.data || got.last !== want.last)
                        flag_error("Transfer mismatch", want, got);
                end
            end
        end
    end

    task automatic send_setup(input t_setup_row row);
        start           <= 1'b1;
        i_request_type  <= row.rtype;
        i_request_code  <= row.code;
        i_request_value <= row.value;
        row_fixed       <= row.fixed;
        row_reply       <= row.reply;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_endpoint(input logic [3:0] ep);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= ep;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed standard requests with random content, the rest noise.
    function automatic t_setup_row random_setup();
        t_setup_row row;
        int         pick;
        row.rtype = 8'($urandom);
        row.code  = 8'($urandom);
        row.value = 16'($urandom);
        row.fixed = 1'b0;
        row.reply = R_CALC;
        pick = $urandom_range(99);
        if (pick < 85) row.rtype[6:5] = TYPE_STANDARD;
        if (pick < 60) begin
            case ($urandom_range(5))
                0, 1, 2: begin
                    row.code = REQ_GET_DESCRIPTOR;
                    row.value[15:8] = 8'($urandom_range(1, 3));
                    if ($urandom_range(1) == 0) row.value[7:0] = 8'h00;
                end
                3:       row.code = REQ_GET_CONFIG;
                4:       row.code = REQ_GET_INTERFACE;
                default: row.code = REQ_SET_INTERFACE;
            endcase
        end else if (pick < 75) begin
            row.code = REQ_GET_DESCRIPTOR;
        end
        return row;
    endfunction

    initial begin
        logic [3:0] phase_ep [4];
        phase_ep = '{4'hf, 4'h0, 4'h9, 4'h6};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            send_setup(DIRECTED[i]);
            if ($urandom_range(3) == 0) hold_off($urandom_range(1, 15));
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            write_endpoint(phase < 4 ? phase_ep[phase] : 4'($urandom_range(15)));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_setup(random_setup());
                // The final phase runs back to back.
                if (phase < PHASES - 1 && $urandom_range(99) < 35)
                    hold_off($urandom_range(1, 15));
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        while (expected_replies.size() != 0)
            flag_error("Missing transfer", expected_replies.pop_front(), R_CALC);

        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/usr_pkg.sv
rtl/core/usr_decode.sv
rtl/core/usr_emitter.sv
rtl/core/usb_standard_request_responder.sv
tb/usb_standard_request_responder_test.sv
